### hw/rtl/banked_value_histogram_macros.svh
// Assertion macros shared by the histogram checker.
`ifndef BANKED_VALUE_HISTOGRAM_MACROS_SVH
`define BANKED_VALUE_HISTOGRAM_MACROS_SVH

// Same-cycle implication, sampled on i_clk and held off during reset.
`define BVH_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and held off during reset.
`define BVH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bvh_pkg.sv
// Types and constants shared by the banked value histogram modules.
package bvh_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] REG_BIN_SCALE  = 2'd2;

    // Configuration reset values: range 0.0 to 40.0, scale for 64 bins.
    localparam logic signed [31:0] RANGE_LOW_RST  = 32'sd0;
    localparam logic signed [31:0] RANGE_HIGH_RST = 32'sd2621440;
    localparam logic [31:0]        BIN_SCALE_RST  = 32'd104858;

    // Input item.
    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         bank;
        logic signed [31:0] sample;
        logic [5:0]         read_bin;
    } t_hist_in;

    // Result item.
    typedef struct packed {
        logic        in_range;
        logic [5:0]  bin_index;
        logic [31:0] bin_count;
        logic [31:0] bank_total;
        logic [31:0] out_count;
    } t_hist_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld;
        logic calc;
        logic mul;
        logic rd;
        logic commit;
        logic clr_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } t_status;

endpackage

### hw/rtl/bvh_ctrl.sv
// Controller state machine of the banked value histogram.
module bvh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_in_op,
    input  logic            i_out_stall,
    input  bvh_pkg::t_status i_status,
    output bvh_pkg::t_cmd   o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);
    import bvh_pkg::*;

    typedef enum logic [6:0] {
        S_INIT = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_CALC = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_WR   = 7'b0100000,
        S_CLR  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   accept;

    // The result register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = (r_state == S_IDLE) && i_in_valid;

    // Next state and commands.
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.ld       = accept;
        o_cmd.calc     = (r_state == S_CALC);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.rd       = (r_state == S_RD);
        o_cmd.commit   = (r_state == S_WR) && out_free;
        o_cmd.clr_step = (r_state == S_INIT) || (r_state == S_CLR);
        unique case (r_state)
            S_INIT: begin
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_op)
                        OP_ADD:   n_state = S_CALC;
                        OP_READ:  n_state = S_RD;
                        OP_CLEAR: n_state = S_CLR;
                        default:  n_state = S_WR;
                    endcase
                end
            end
            S_CALC: n_state = S_MUL;
            S_MUL:  n_state = S_RD;
            S_RD:   n_state = S_WR;
            S_WR: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                if (i_status.clr_last) begin
                    n_state = S_WR;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // Result valid: set on commit, cleared once the transfer completes.
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/bvh_datapath.sv
// Datapath of the banked value histogram: configuration, binning and count memories.
module bvh_datapath #(
    parameter int NUM_BINS  = 64,
    parameter int NUM_BANKS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_wdata,
    input  bvh_pkg::t_hist_in i_in_data,
    input  bvh_pkg::t_cmd     i_cmd,
    output bvh_pkg::t_status  o_status,
    output bvh_pkg::t_hist_out o_out_data
);
    import bvh_pkg::*;

    localparam int          DEPTH    = NUM_BANKS * NUM_BINS;
    localparam int          AW       = $clog2(DEPTH);
    localparam int          BW       = $clog2(NUM_BINS);
    localparam int          BKW      = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam logic [31:0] LAST_BIN = 32'(NUM_BINS - 1);

    // Configuration registers.
    logic signed [31:0] r_lo;
    logic signed [31:0] r_hi;
    logic [31:0]        r_scale;

    // Item and intermediate values.
    t_hist_in    r_item;
    logic        r_bank_ok;
    logic [AW-1:0] r_base;
    logic        r_in_range;
    logic [31:0] r_diff;
    logic [31:0] r_bin_hi;
    logic [BW-1:0] r_bin;
    logic [AW-1:0] r_addr;
    logic [31:0] r_cnt_q;
    logic [31:0] r_tot_q;
    logic [31:0] r_out_q;
    t_hist_out   r_res;
    t_hist_out   n_res;

    // Count memories.
    logic [31:0] r_bin_mem [DEPTH];
    logic [31:0] r_tot_mem [NUM_BANKS];
    logic [31:0] r_oor_mem [NUM_BANKS];

    // Clear sweep pointer.
    logic [AW-1:0] r_clr_idx;

    logic [63:0]   product;
    logic [BW-1:0] bin_clamp;
    logic [BW-1:0] bin_sel;
    logic [AW-1:0] rd_addr;
    logic [BKW-1:0] bank_idx;
    logic          rbin_ok;
    logic          add_commit;
    logic          clr_bank_hit;
    logic          bin_we;
    logic [AW-1:0] bin_waddr;
    logic [31:0]   bin_wdata;
    logic          tot_we;
    logic          oor_we;
    logic [BKW-1:0] bank_waddr;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo    <= RANGE_LOW_RST;
            r_hi    <= RANGE_HIGH_RST;
            r_scale <= BIN_SCALE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_RANGE_LOW:  r_lo    <= $signed(i_cfg_wdata);
                REG_RANGE_HIGH: r_hi    <= $signed(i_cfg_wdata);
                REG_BIN_SCALE:  r_scale <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Item capture with the bank check and the bank's base address.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_item    <= i_in_data;
            r_bank_ok <= (32'(i_in_data.bank) < 32'(NUM_BANKS));
            r_base    <= AW'(32'(i_in_data.bank) * 32'(NUM_BINS));
        end
    end

    // Range test and offset from the lower bound.
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_in_range <= r_bank_ok && (r_item.sample > r_lo) && (r_item.sample < r_hi);
            r_diff     <= $unsigned(r_item.sample - r_lo);
        end
    end

    // Scale the offset; the bin is the upper half of the product.
    assign product = 64'(r_diff) * 64'(r_scale);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_bin_hi <= product[63:32];
        end
    end

    // Clamp to the last bin and form the memory address.
    assign bin_clamp = (r_bin_hi > LAST_BIN) ? BW'(LAST_BIN) : BW'(r_bin_hi);
    assign bin_sel   = (r_item.op == OP_ADD) ? bin_clamp : BW'(r_item.read_bin);
    assign rd_addr   = r_base + AW'(bin_sel);
    assign bank_idx  = BKW'(r_item.bank);
    assign rbin_ok   = (32'(r_item.read_bin) < 32'(NUM_BINS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_bin  <= bin_clamp;
            r_addr <= rd_addr;
        end
    end

    // Clear sweep pointer wraps to zero after the last entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_idx <= o_status.clr_last ? '0 : r_clr_idx + AW'(1);
        end
    end

    assign o_status.clr_last = (r_clr_idx == AW'(DEPTH - 1));
    assign clr_bank_hit      = (r_clr_idx < AW'(NUM_BANKS));
    assign add_commit        = i_cmd.commit && (r_item.op == OP_ADD) && r_bank_ok;

    // Write port selection: clear sweep or read-modify-write of an add.
    always_comb begin
        if (i_cmd.clr_step) begin
            bin_we     = 1'b1;
            bin_waddr  = r_clr_idx;
            bin_wdata  = '0;
            tot_we     = clr_bank_hit;
            oor_we     = clr_bank_hit;
            bank_waddr = r_clr_idx[BKW-1:0];
        end else begin
            bin_we     = add_commit && r_in_range;
            bin_waddr  = r_addr;
            bin_wdata  = sat_inc(r_cnt_q);
            tot_we     = add_commit && r_in_range;
            oor_we     = add_commit && !r_in_range;
            bank_waddr = bank_idx;
        end
    end

    // Bin count memory.
    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            r_bin_mem[bin_waddr] <= bin_wdata;
        end
        if (i_cmd.rd) begin
            r_cnt_q <= r_bin_mem[rd_addr];
        end
    end

    // Bank total memory.
    always_ff @(posedge i_clk) begin
        if (tot_we) begin
            r_tot_mem[bank_waddr] <= i_cmd.clr_step ? 32'd0 : sat_inc(r_tot_q);
        end
        if (i_cmd.rd) begin
            r_tot_q <= r_tot_mem[bank_idx];
        end
    end

    // Out-of-range count memory.
    always_ff @(posedge i_clk) begin
        if (oor_we) begin
            r_oor_mem[bank_waddr] <= i_cmd.clr_step ? 32'd0 : sat_inc(r_out_q);
        end
        if (i_cmd.rd) begin
            r_out_q <= r_oor_mem[bank_idx];
        end
    end

    // Result assembly.
    always_comb begin
        n_res = '0;
        case (r_item.op)
            OP_ADD: begin
                n_res.in_range  = r_in_range;
                n_res.bin_index = r_in_range ? 6'(r_bin) : 6'd0;
            end
            OP_READ: begin
                n_res.bin_index = r_item.read_bin;
                if (r_bank_ok) begin
                    n_res.bin_count  = rbin_ok ? r_cnt_q : 32'd0;
                    n_res.bank_total = r_tot_q;
                    n_res.out_count  = r_out_q;
                end
            end
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res <= n_res;
        end
    end

    assign o_out_data = r_res;

endmodule

### hw/rtl/banked_value_histogram.sv
// Banked value histogram: NUM_BANKS histograms of NUM_BINS saturating bins each.
// An add runs the range test, the registered 32x32 scale multiply and the bin memory
// read-modify-write; a read only the memory read, an unused op none of these, and a
// clear sweeps every entry of every bank, one entry a cycle. A new item is taken only
// once the result of the last one has been committed.
// Reset runs a clearing pass with input stalled.
module banked_value_histogram #(
    parameter int NUM_BINS  = 64,
    parameter int NUM_BANKS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bvh_pkg::t_hist_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bvh_pkg::t_hist_out o_out_data
);
    import bvh_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencing of each transfer.
    bvh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_data.op),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Binning arithmetic and count storage.
    bvh_datapath #(
        .NUM_BINS  (NUM_BINS),
        .NUM_BANKS (NUM_BANKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

### hw/rtl/bvh_checker.sv
// Port-level checks of the banked value histogram and their bind.
`include "banked_value_histogram_macros.svh"

module bvh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input bvh_pkg::t_hist_out o_out_data
);
    import bvh_pkg::*;

    // A stalled result stays valid and unchanged.
    `BVH_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "result changed while stalled")

    // Only one item is in work at a time.
    `BVH_ASSERT_NEXT(a_one_item, i_in_valid && !o_in_stall, o_in_stall, "second item taken while one is in work")

    // The clearing pass after reset holds off input transfers.
    `BVH_ASSERT_IMPLY(a_sweep_after_reset, !$past(i_rst_n), o_in_stall, "input taken before the clearing pass")

    // An add result carries no counts.
    `BVH_ASSERT_IMPLY(a_add_no_counts, o_out_valid && o_out_data.in_range, o_out_data.bin_count == 32'd0 && o_out_data.bank_total == 32'd0 && o_out_data.out_count == 32'd0, "add result has counts")

endmodule

bind banked_value_histogram bvh_checker u_bvh_checker (.*);

### sim/tb.sv
// Self-checking testbench for the banked value histogram: directed and random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bvh_pkg::*;

    localparam int NUM_BINS        = 64;
    localparam int NUM_BANKS       = 8;
    localparam int SWEEP_CYCLES    = NUM_BANKS * NUM_BINS + 8;
    localparam int STUCK_LIMIT     = 5000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 88;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Histogram predictor: mirrors the bank memories and the range registers.
    class hist_scoreboard;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic [31:0]        bin_scale;
        bit [31:0]          bin_counts [NUM_BANKS][NUM_BINS];
        bit [31:0]          bank_totals [NUM_BANKS];
        bit [31:0]          out_counts [NUM_BANKS];
        int                 last_bin [NUM_BANKS];
        t_hist_out          predicted_reports [$];
        int                 errors;

        function new();
            range_low  = RANGE_LOW_RST;
            range_high = RANGE_HIGH_RST;
            bin_scale  = BIN_SCALE_RST;
            errors     = 0;
            wipe_banks();
            foreach (last_bin[b]) last_bin[b] = 0;
        endfunction

        function void set_range(logic [31:0] lo, logic [31:0] hi, logic [31:0] scale);
            range_low  = lo;
            range_high = hi;
            bin_scale  = scale;
        endfunction

        function void wipe_banks();
            foreach (bin_counts[b, k]) bin_counts[b][k] = '0;
            foreach (bank_totals[b]) begin
                bank_totals[b] = '0;
                out_counts[b]  = '0;
            end
        endfunction

        function bit [31:0] sat_inc(bit [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        // Update the banks for one accepted transfer and return its report.
        function t_hist_out apply_item(t_hist_in item);
            t_hist_out       res;
            longint          s;
            longint          lo;
            longint          hi;
            longint unsigned diff;
            longint unsigned bin;
            res = '0;
            s   = $signed(item.sample);
            lo  = range_low;
            hi  = range_high;
            case (item.op)
                OP_ADD: begin
                    if (s > lo && s < hi) begin
                        diff = s - lo;
                        bin  = (diff * bin_scale) >> 32;
                        if (bin > NUM_BINS - 1) bin = NUM_BINS - 1;
                        bin_counts[item.bank][bin] = sat_inc(bin_counts[item.bank][bin]);
                        bank_totals[item.bank] = sat_inc(bank_totals[item.bank]);
                        last_bin[item.bank] = int'(bin);
                        res.in_range  = 1'b1;
                        res.bin_index = 6'(bin);
                    end else begin
                        out_counts[item.bank] = sat_inc(out_counts[item.bank]);
                    end
                end
                OP_READ: begin
                    res.bin_index  = item.read_bin;
                    res.bin_count  = bin_counts[item.bank][item.read_bin];
                    res.bank_total = bank_totals[item.bank];
                    res.out_count  = out_counts[item.bank];
                end
                OP_CLEAR: begin
                    wipe_banks();
                end
                default: begin
                end
            endcase
            return res;
        endfunction

        function void note_input(t_hist_in item);
            predicted_reports.push_back(apply_item(item));
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_hist_out got);
            t_hist_out want;
            if (predicted_reports.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result: expected none, actual %h", $time, got);
                return;
            end
            want = predicted_reports.pop_front();
            compare_field("in_range", want.in_range, got.in_range);
            compare_field("bin_index", want.bin_index, got.bin_index);
            compare_field("bin_count", want.bin_count, got.bin_count);
            compare_field("bank_total", want.bank_total, got.bank_total);
            compare_field("out_count", want.out_count, got.out_count);
        endfunction

        function int pending();
            return predicted_reports.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [1:0] i_cfg_index;
    logic [31:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_stall;
    t_hist_in   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_hist_out  o_out_data;

    hist_scoreboard sb;
    int sender_idle_pct;
    int receiver_stall_pct;
    int stuck_cycles = 0;

    banked_value_histogram u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 12 ns clock.
    always begin
        #6;
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
    end

    // The result side stalls at random according to the current phase.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Check every result transfer and watch for a hung block.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                sb.check_result(o_out_data);
            end
            if ((o_out_valid === 1'b1 && i_out_stall === 1'b0) ||
                (i_in_valid === 1'b1 && o_in_stall === 1'b0)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // Offer one item, with random idle cycles ahead of it; returns at a falling edge.
    task automatic send_item(input t_hist_in item);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_input(item);
        @(negedge i_clk);
    endtask

    task automatic write_one(input logic [1:0] index, input logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [31:0] lo, input logic [31:0] hi,
                                input logic [31:0] scale);
        write_one(REG_RANGE_LOW, lo);
        write_one(REG_RANGE_HIGH, hi);
        write_one(REG_BIN_SCALE, scale);
        i_cfg_wr_en <= 1'b0;
        sb.set_range(lo, hi, scale);
    endtask

    // Wait for every report, then let a possible clear sweep finish.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SWEEP_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_hist_in make_item(logic [1:0] op, logic [2:0] bank,
                                           logic [31:0] sample, logic [5:0] rbin);
        t_hist_in it;
        it.op       = op;
        it.bank     = bank;
        it.sample   = sample;
        it.read_bin = rbin;
        return it;
    endfunction

    // Samples cluster around the current range, with its edges and wide noise mixed in.
    function automatic logic [31:0] random_sample();
        longint          lo;
        longint          hi;
        longint          span;
        longint          v;
        longint unsigned r64;
        int unsigned     pick;
        lo   = sb.range_low;
        hi   = sb.range_high;
        r64  = {$urandom, $urandom};
        pick = $urandom_range(99);
        span = (hi > lo) ? hi - lo : 64'sd4096;
        if (pick < 10) begin
            v = longint'($urandom);
        end else if (pick < 22) begin
            case ($urandom_range(5))
                0: v = lo;
                1: v = hi;
                2: v = lo + 1;
                3: v = hi - 1;
                4: v = lo - 1;
                default: v = hi + 1;
            endcase
        end else begin
            v = lo - span / 16 + longint'(r64 % longint'(span + span / 8 + 1));
        end
        return 32'(v);
    endfunction

    function automatic t_hist_in random_item();
        t_hist_in    it;
        int unsigned pick;
        pick        = $urandom_range(999);
        it.bank     = 3'($urandom_range(NUM_BANKS - 1));
        it.sample   = random_sample();
        it.read_bin = $urandom_range(1) ? 6'(sb.last_bin[it.bank]) : 6'($urandom_range(63));
        if (pick < 15)       it.op = OP_CLEAR;
        else if (pick < 45)  it.op = OP_UNUSED;
        else if (pick < 330) it.op = OP_READ;
        else                 it.op = OP_ADD;
        return it;
    endfunction

    // Range setting of one phase: reset values, extremes, a zero scale, empty ranges, random ranges.
    task automatic configure_phase(input int phase);
        longint          width;
        longint          lo;
        longint          scale;
        longint unsigned r64;
        r64   = {$urandom, $urandom};
        width = (longint'(1) << $urandom_range(12, 31)) + longint'($urandom_range(0, 4095));
        lo    = -64'sd2147483648 + longint'(r64 % longint'((longint'(1) << 32) - width));
        scale = (longint'(NUM_BINS) << 32) / width;
        if ($urandom_range(1)) scale = scale + scale / 8;
        if (scale > 64'sd4294967295) scale = 64'sd4294967295;
        case (phase)
            0: program_regs(RANGE_LOW_RST, RANGE_HIGH_RST, BIN_SCALE_RST);
            1: program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
            2: program_regs(-32'sd2621440, 32'sd2621440, 32'd0);
            3: program_regs(32'h7FFF_FFFF, 32'h8000_0000, $urandom);
            5: program_regs(32'(lo), 32'(lo), 32'(scale));
            default: program_regs(32'(lo), 32'(lo + width), 32'(scale));
        endcase
    endtask

    // Idling modes: none, sender gaps, receiver stalls, both.
    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            1: begin
                sender_idle_pct    = 59;
                receiver_stall_pct = 0;
            end
            2: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 59;
            end
            default: begin
                sender_idle_pct    = 26;
                receiver_stall_pct = 26;
            end
        endcase
    endtask

    initial begin
        int item_count;
        t_hist_in item;
        sb                 = new();
        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_index        = REG_RANGE_LOW;
        i_cfg_wdata        = '0;
        i_in_valid         = 1'b0;
        i_in_data          = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        program_regs(RANGE_LOW_RST, RANGE_HIGH_RST, BIN_SCALE_RST);

        // Directed: range bounds, the clamp to the last bin, extreme samples,
        // reads of filled and empty banks, the unused op and a clear.
        send_item(make_item(OP_ADD, 3'd0, 32'd0, 6'd0));
        send_item(make_item(OP_ADD, 3'd0, 32'd2621440, 6'd0));
        send_item(make_item(OP_ADD, 3'd0, 32'd1, 6'd0));
        send_item(make_item(OP_ADD, 3'd0, 32'd2621439, 6'd0));
        send_item(make_item(OP_ADD, 3'd7, 32'h7FFF_FFFF, 6'd63));
        send_item(make_item(OP_ADD, 3'd7, 32'h8000_0000, 6'd63));
        send_item(make_item(OP_ADD, 3'd7, 32'd1310720, 6'd0));
        send_item(make_item(OP_ADD, 3'd7, 32'd1310720, 6'd0));
        send_item(make_item(OP_ADD, 3'd3, 32'hFFFF_FFFF, 6'd0));
        send_item(make_item(OP_ADD, 3'd5, 32'h0000_FFFF, 6'd0));
        send_item(make_item(OP_READ, 3'd0, 32'd0, 6'd0));
        send_item(make_item(OP_READ, 3'd0, 32'hFFFF_FFFF, 6'd63));
        send_item(make_item(OP_READ, 3'd7, 32'd0, 6'd32));
        send_item(make_item(OP_READ, 3'd7, 32'd0, 6'd63));
        send_item(make_item(OP_READ, 3'd3, 32'd0, 6'd0));
        send_item(make_item(OP_READ, 3'd5, 32'd0, 6'd0));
        send_item(make_item(OP_UNUSED, 3'd7, 32'hFFFF_FFFF, 6'd63));
        send_item(make_item(OP_UNUSED, 3'd0, 32'd0, 6'd0));
        send_item(make_item(OP_CLEAR, 3'd0, 32'd0, 6'd0));
        send_item(make_item(OP_READ, 3'd7, 32'd0, 6'd32));
        send_item(make_item(OP_READ, 3'd0, 32'd0, 6'd63));
        send_item(make_item(OP_ADD, 3'd2, 32'd655360, 6'd0));
        send_item(make_item(OP_READ, 3'd2, 32'd0, 6'd16));

        // Random phases, each with its own range setting and idling mode.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            configure_phase(phase);
            set_idling(phase % 4);
            item_count = 0;
            while (item_count < ITEMS_PER_PHASE) begin
                item = random_item();
                send_item(item);
                if (item.op != OP_UNUSED) item_count++;
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (32) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

### banked_value_histogram.f
+incdir+hw/rtl
hw/rtl/bvh_pkg.sv
hw/rtl/bvh_ctrl.sv
hw/rtl/bvh_datapath.sv
hw/rtl/banked_value_histogram.sv
hw/rtl/bvh_checker.sv
sim/tb.sv
